@@ design/lmpc_pkg.sv @@
package lmpc_pkg;

  localparam int GUARD_BITS = 8;
  localparam int FRAC_BITS  = 8 + GUARD_BITS;

  // widths of the fixed-point terms
  localparam int FACT_W = FRAC_BITS + 1;        // fraction of 1.0, up to 1.0 itself
  localparam int CORE_W = FRAC_BITS + 7;        // brightness knee term
  localparam int LIT_W  = FRAC_BITS + 10;       // lit channel, byte scale
  localparam int PROD_W = LIT_W + FACT_W;       // lit times level
  localparam int AMB_W  = 8 + FACT_W;           // ambient times darkness
  localparam int SUM_W  = 2 * FRAC_BITS + 10;   // blended channel before rounding
  localparam int RES_W  = SUM_W - 2 * FRAC_BITS;

  localparam int LUT_DEPTH    = 256;
  localparam int ROUND_BIAS   = 127;
  localparam int BYTE_MAX     = 255;
  localparam int KNEE_LEVEL   = 179;            // first byte above 0.7
  localparam int KNEE_TWICE   = 357;            // 2 * 178.5

  localparam logic [FACT_W-1:0] FRAC_ONE = FACT_W'(1) << FRAC_BITS;
  localparam logic [7:0]        LEVEL_FULL = 8'(BYTE_MAX);

  typedef logic [FACT_W-1:0] frac_t;
  typedef frac_t frac_lut_t [LUT_DEPTH];

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    frac_t             gq;    // brightness as fraction
    frac_t             rq;    // level as fraction
    frac_t             dq;    // darkness, 1 - level
    logic [CORE_W-1:0] core;  // extra light above the knee
  } factor_t;

  typedef struct packed {
    logic s1_load;
    logic s2_load;
  } adv_t;

  typedef enum logic [1:0] {
    REG_AMBIENT_RED   = 2'd0,
    REG_AMBIENT_GREEN = 2'd1,
    REG_AMBIENT_BLUE  = 2'd2
  } reg_index_t;

  // byte to fraction of 1.0, rounded: floor((b * 2^F + 127) / 255)
  function automatic frac_lut_t build_frac_lut();
    frac_lut_t lut;
    for (int i = 0; i < LUT_DEPTH; i++) begin
      lut[i] = FACT_W'(((longint'(i) << FRAC_BITS) + ROUND_BIAS) / 255);
    end
    return lut;
  endfunction

  localparam frac_lut_t FRAC_LUT = build_frac_lut();

endpackage

@@ design/lightmap_pixel_combine_unit.sv @@
// Per-pixel dynamic-light combine: brightens a scene pixel by the lightmap
// brightness, blends it toward the programmable ambient color by the lightmap
// darkness, then rounds and saturates each channel. The block takes one pixel
// per clock while in_stall is low and passes each beat through a register after
// the factor lookup, one after the brighten multiply, and the output register
// after the blend multiply, with the three color channels worked in parallel
// lanes; the two multiplies in each lane set the pipeline depth. out_stall holds
// the whole pipeline only once every stage is full, so bubbles are squeezed out.
// Ambient registers are to be written by the user through the cfg port only while
// no pixel is in flight; the block itself does not enforce this. cfg_ready is
// always high and writes to an index beyond the ambient blue register are dropped.
module lightmap_pixel_combine_unit (
  input  logic       clk,
  input  logic       rst_n,

  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_pixel_red,
  input  logic [7:0] in_pixel_green,
  input  logic [7:0] in_pixel_blue,
  input  logic [7:0] in_light_level,
  input  logic [7:0] in_light_brightness,

  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic       out_passed_through,

  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  lmpc_pkg::rgb_t    amb_r, amb_nxt;
  logic              v1_r, v1_nxt;
  logic              v2_r, v2_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              ready1, ready2, ready_out;
  logic              out_load;
  lmpc_pkg::adv_t    adv;
  lmpc_pkg::rgb_t    pix_in;
  lmpc_pkg::rgb_t    pix1_r, pix2_r;
  logic              pass1, pass2_r;
  lmpc_pkg::factor_t factor1;
  lmpc_pkg::rgb_t    lane_rgb;
  lmpc_pkg::rgb_t    rgb_out;

  assign cfg_ready = 1'b1;

  always_comb begin
    amb_nxt = amb_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lmpc_pkg::REG_AMBIENT_RED:   amb_nxt.red   = cfg_data;
        lmpc_pkg::REG_AMBIENT_GREEN: amb_nxt.green = cfg_data;
        lmpc_pkg::REG_AMBIENT_BLUE:  amb_nxt.blue  = cfg_data;
        default:                     amb_nxt       = amb_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amb_r <= '0;
    end else begin
      amb_r <= amb_nxt;
    end
  end

  // pipeline control: a stage loads when the one after it can take its beat
  always_comb begin
    ready_out     = !out_valid_r || !out_stall;
    ready2        = !v2_r || ready_out;
    ready1        = !v1_r || ready2;
    adv.s1_load   = ready1 && in_valid;
    adv.s2_load   = ready2 && v1_r;
    out_load      = ready_out && v2_r;
    v1_nxt        = ready1 ? in_valid : v1_r;
    v2_nxt        = ready2 ? v1_r : v2_r;
    out_valid_nxt = ready_out ? v2_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall = !ready1;

  assign pix_in.red   = in_pixel_red;
  assign pix_in.green = in_pixel_green;
  assign pix_in.blue  = in_pixel_blue;

  // carry the scene pixel alongside the lanes for the pass-through case
  always_ff @(posedge clk) begin
    if (adv.s1_load) begin
      pix1_r <= pix_in;
    end
    if (adv.s2_load) begin
      pix2_r  <= pix1_r;
      pass2_r <= pass1;
    end
  end

  lmpc_factor u_factor (
    .clk        (clk),
    .load       (adv.s1_load),
    .level      (in_light_level),
    .brightness (in_light_brightness),
    .factor_r   (factor1),
    .pass_r     (pass1)
  );

  lmpc_lane u_lane_red (
    .clk     (clk),
    .adv     (adv),
    .pixel   (pix1_r.red),
    .ambient (amb_r.red),
    .factor  (factor1),
    .result  (lane_rgb.red)
  );

  lmpc_lane u_lane_green (
    .clk     (clk),
    .adv     (adv),
    .pixel   (pix1_r.green),
    .ambient (amb_r.green),
    .factor  (factor1),
    .result  (lane_rgb.green)
  );

  lmpc_lane u_lane_blue (
    .clk     (clk),
    .adv     (adv),
    .pixel   (pix1_r.blue),
    .ambient (amb_r.blue),
    .factor  (factor1),
    .result  (lane_rgb.blue)
  );

  lmpc_merge u_merge (
    .clk      (clk),
    .load     (out_load),
    .lane_rgb (lane_rgb),
    .pixel    (pix2_r),
    .pass     (pass2_r),
    .rgb_r    (rgb_out),
    .pass_r   (out_passed_through)
  );

  assign out_valid = out_valid_r;
  assign out_red   = rgb_out.red;
  assign out_green = rgb_out.green;
  assign out_blue  = rgb_out.blue;

  // input may stall only when every stage holds a beat
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v1_r && v2_r && out_valid_r))
    else $error("input stalled with a free pipeline stage");

  // a delivered beat with nothing behind it must not be shown again
  a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && !v2_r) |=> !out_valid_r)
    else $error("output beat repeated");

  // a stage-two beat never vanishes while the output is blocked
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !ready_out) |=> v2_r)
    else $error("stage-two beat lost under stall");

  // a pass-through beat carries the scene pixel unchanged
  a_pass_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && pass2_r) |=> (rgb_out == $past(pix2_r)) && out_passed_through)
    else $error("pass-through pixel altered");

endmodule

@@ design/lmpc_factor.sv @@
module lmpc_factor (
  input  logic                 clk,
  input  logic                 load,
  input  logic [7:0]           level,
  input  logic [7:0]           brightness,
  output lmpc_pkg::factor_t    factor_r,
  output logic                 pass_r
);

  lmpc_pkg::factor_t factor_nxt;
  logic              pass_nxt;
  logic [8:0]        twice;
  logic [8:0]        knee_diff;

  always_comb begin
    twice     = {brightness, 1'b0};
    knee_diff = twice - 9'(lmpc_pkg::KNEE_TWICE);

    factor_nxt.gq = lmpc_pkg::FRAC_LUT[brightness];
    factor_nxt.rq = lmpc_pkg::FRAC_LUT[level];
    factor_nxt.dq = lmpc_pkg::FRAC_ONE - lmpc_pkg::FRAC_LUT[level];
    if (brightness >= 8'(lmpc_pkg::KNEE_LEVEL)) begin
      factor_nxt.core = lmpc_pkg::CORE_W'(knee_diff[7:0]) << (lmpc_pkg::FRAC_BITS - 1);
    end else begin
      factor_nxt.core = '0;
    end

    pass_nxt = (level == lmpc_pkg::LEVEL_FULL) && (brightness == 8'd0);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      factor_r <= factor_nxt;
      pass_r   <= pass_nxt;
    end
  end

endmodule

@@ design/lmpc_lane.sv @@
module lmpc_lane (
  input  logic                 clk,
  input  lmpc_pkg::adv_t       adv,
  input  logic [7:0]           pixel,
  input  logic [7:0]           ambient,
  input  lmpc_pkg::factor_t    factor,
  output logic [7:0]           result
);

  logic [lmpc_pkg::LIT_W-1:0]  lit_nxt, lit_r;
  logic [lmpc_pkg::AMB_W-1:0]  amb_dq_nxt, amb_dq_r;
  lmpc_pkg::frac_t             rq_r;
  logic [lmpc_pkg::FACT_W:0]   gain;
  logic [lmpc_pkg::PROD_W-1:0] prod;
  logic [lmpc_pkg::SUM_W-1:0]  sum;
  logic [lmpc_pkg::RES_W-1:0]  res;

  localparam logic [lmpc_pkg::SUM_W-1:0] ROUND_HALF =
    lmpc_pkg::SUM_W'(1) << (2 * lmpc_pkg::FRAC_BITS - 1);

  // first multiply: brighten the scene channel and scale the ambient by the darkness
  always_comb begin
    gain       = (lmpc_pkg::FACT_W + 1)'(lmpc_pkg::FRAC_ONE)
               + (lmpc_pkg::FACT_W + 1)'(factor.gq);
    lit_nxt    = lmpc_pkg::LIT_W'(pixel) * lmpc_pkg::LIT_W'(gain)
               + lmpc_pkg::LIT_W'(factor.core);
    amb_dq_nxt = lmpc_pkg::AMB_W'(ambient) * lmpc_pkg::AMB_W'(factor.dq);
  end

  always_ff @(posedge clk) begin
    if (adv.s2_load) begin
      lit_r    <= lit_nxt;
      amb_dq_r <= amb_dq_nxt;
      rq_r     <= factor.rq;
    end
  end

  // second multiply: blend toward ambient, round half up, saturate
  always_comb begin
    prod = lmpc_pkg::PROD_W'(lit_r) * lmpc_pkg::PROD_W'(rq_r);
    sum  = lmpc_pkg::SUM_W'(prod)
         + (lmpc_pkg::SUM_W'(amb_dq_r) << lmpc_pkg::FRAC_BITS)
         + ROUND_HALF;
    res  = sum[lmpc_pkg::SUM_W-1 -: lmpc_pkg::RES_W];
    if (res > lmpc_pkg::RES_W'(lmpc_pkg::BYTE_MAX)) begin
      result = 8'(lmpc_pkg::BYTE_MAX);
    end else begin
      result = res[7:0];
    end
  end

endmodule

@@ design/lmpc_merge.sv @@
module lmpc_merge (
  input  logic           clk,
  input  logic           load,
  input  lmpc_pkg::rgb_t lane_rgb,
  input  lmpc_pkg::rgb_t pixel,
  input  logic           pass,
  output lmpc_pkg::rgb_t rgb_r,
  output logic           pass_r
);

  lmpc_pkg::rgb_t rgb_nxt;

  // fully lit and no brightness: hand the scene pixel back untouched
  always_comb begin
    if (pass) begin
      rgb_nxt = pixel;
    end else begin
      rgb_nxt = lane_rgb;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rgb_r  <= rgb_nxt;
      pass_r <= pass;
    end
  end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps

module tb;

  localparam int          FRAC       = lmpc_pkg::FRAC_BITS;
  localparam logic [63:0] ONE        = 64'd1 << FRAC;
  localparam logic [7:0]  KNEE_BYTE  = 8'd179;    // first brightness byte above 0.7
  localparam logic [1:0]  REG_NONE   = 2'd3;      // no register behind this index
  localparam int          N_PHASES   = 7;
  localparam int          PHASE_PIX  = 150;
  localparam int          LONG_HOLD  = 64;
  localparam int          SETTLE     = 6;
  localparam int          LIMIT      = 200000;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] level;
    logic [7:0] bright;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       passed;
  } lit_px_t;

  // directed probe: pixel, lightmap texel, and a hand-read result where known
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] level;
    logic [7:0] bright;
    logic       known;
    logic [7:0] w_red;
    logic [7:0] w_green;
    logic [7:0] w_blue;
    logic       w_passed;
  } probe_t;

  // ambient is zero out of reset, so level zero must give black
  localparam probe_t PROBES [15] = '{
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00, 8'h00, 8'h00, 1'b0},
    '{8'hff, 8'hff, 8'hff, 8'h00, 8'hff, 1'b1, 8'h00, 8'h00, 8'h00, 1'b0},
    '{8'h12, 8'h34, 8'h56, 8'hff, 8'h00, 1'b1, 8'h12, 8'h34, 8'h56, 1'b1},
    '{8'hff, 8'h00, 8'h80, 8'hff, 8'h00, 1'b1, 8'hff, 8'h00, 8'h80, 1'b1},
    '{8'h00, 8'hff, 8'h00, 8'hff, 8'h00, 1'b1, 8'h00, 8'hff, 8'h00, 1'b1},
    '{8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1, 8'hff, 8'hff, 8'hff, 1'b0},
    '{8'hff, 8'hff, 8'hff, 8'hff, 8'h01, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
    '{8'h80, 8'h80, 8'h80, 8'hfe, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
    '{8'h80, 8'h40, 8'h20, 8'hff, 8'h01, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
    '{8'h00, 8'h01, 8'h02, 8'hff, 8'hb2, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
    '{8'h00, 8'h01, 8'h02, 8'hff, 8'hb3, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
    '{8'h7f, 8'h80, 8'hfe, 8'h01, 8'hff, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
    '{8'haa, 8'h55, 8'h01, 8'h80, 8'h40, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
    '{8'h01, 8'hfe, 8'h7f, 8'h7f, 8'hb3, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
    '{8'hc3, 8'h3c, 8'h5a, 8'h00, 8'h00, 1'b1, 8'h00, 8'h00, 8'h00, 1'b0}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_pixel_red = 8'h00;
  logic [7:0] in_pixel_green = 8'h00;
  logic [7:0] in_pixel_blue = 8'h00;
  logic [7:0] in_light_level = 8'h00;
  logic [7:0] in_light_brightness = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       out_passed_through;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = 2'd0;
  logic [7:0] cfg_data = 8'h00;

  logic [7:0] amb_red = 8'h00;
  logic [7:0] amb_green = 8'h00;
  logic [7:0] amb_blue = 8'h00;

  lit_px_t combined_q [$];
  int      cycles = 0;
  int      mismatches = 0;
  int      pixels_in = 0;
  int      beats_out = 0;
  int      passes_seen = 0;
  int      settings = 0;
  int      hold_asks = 0;
  int      hold_seen = 0;
  int      hold_left = 0;
  logic    steady = 1'b0;

  lightmap_pixel_combine_unit uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_pixel_red        (in_pixel_red),
    .in_pixel_green      (in_pixel_green),
    .in_pixel_blue       (in_pixel_blue),
    .in_light_level      (in_light_level),
    .in_light_brightness (in_light_brightness),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_red             (out_red),
    .out_green           (out_green),
    .out_blue            (out_blue),
    .out_passed_through  (out_passed_through),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always #5 clk = ~clk;

  // byte with 255 = 1.0, as a fraction of one with FRAC bits, rounded
  function automatic logic [63:0] frac_of(input logic [7:0] b);
    return ((64'(b) << FRAC) + 64'd127) / 64'd255;
  endfunction

  function automatic logic [7:0] blend_channel(input logic [7:0] p, input logic [7:0] amb,
                                               input logic [63:0] gq, input logic [63:0] rq,
                                               input logic [63:0] knee);
    logic [63:0] lit;
    logic [63:0] mix;
    logic [63:0] q;
    lit = 64'(p) * (ONE + gq) + knee;
    mix = lit * rq + (64'(amb) << FRAC) * (ONE - rq);
    q   = (mix + (64'd1 << (2 * FRAC - 1))) >> (2 * FRAC);
    return (q > 64'd255) ? 8'hff : q[7:0];
  endfunction

  function automatic lit_px_t combine_pixel(input pix_in_t px);
    lit_px_t     res;
    logic [63:0] gq;
    logic [63:0] rq;
    logic [63:0] knee;
    res.red    = px.red;
    res.green  = px.green;
    res.blue   = px.blue;
    res.passed = 1'b1;
    if (px.level == 8'hff && px.bright == 8'h00) return res;
    gq   = frac_of(px.bright);
    rq   = frac_of(px.level);
    knee = (px.bright >= KNEE_BYTE) ? ((64'(px.bright) << 1) - 64'd357) << (FRAC - 1) : 64'd0;
    res.red    = blend_channel(px.red,   amb_red,   gq, rq, knee);
    res.green  = blend_channel(px.green, amb_green, gq, rq, knee);
    res.blue   = blend_channel(px.blue,  amb_blue,  gq, rq, knee);
    res.passed = 1'b0;
    return res;
  endfunction

  // lean toward the byte extremes
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic pix_in_t random_pixel();
    pix_in_t px;
    px.red   = pick_byte();
    px.green = pick_byte();
    px.blue  = pick_byte();
    case ($urandom_range(7))
      0: px.level = 8'h00;
      1, 2: px.level = 8'hff;
      3: px.level = 8'hfe;
      default: px.level = 8'($urandom_range(255));
    endcase
    case ($urandom_range(9))
      0, 1: px.bright = 8'h00;
      2: px.bright = 8'hff;
      3: px.bright = 8'hb2;
      4: px.bright = KNEE_BYTE;
      default: px.bright = 8'($urandom_range(255));
    endcase
    return px;
  endfunction

  task automatic send_pixel(input pix_in_t px, input lit_px_t want, input bit no_gaps);
    while (!no_gaps && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_pixel_red        <= px.red;
    in_pixel_green      <= px.green;
    in_pixel_blue       <= px.blue;
    in_light_level      <= px.level;
    in_light_brightness <= px.bright;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    combined_q.insert(combined_q.size(), want);
    pixels_in++;
  endtask

  // every pixel gives one beat, so an empty queue means an empty pipeline
  task automatic wait_drained();
    while (combined_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_ambient(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      case (i)
        0: begin
          cfg_index <= lmpc_pkg::REG_AMBIENT_RED;
          cfg_data  <= r;
        end
        1: begin
          cfg_index <= lmpc_pkg::REG_AMBIENT_GREEN;
          cfg_data  <= g;
        end
        2: begin
          cfg_index <= lmpc_pkg::REG_AMBIENT_BLUE;
          cfg_data  <= b;
        end
        default: begin
          // stray index, must not land anywhere
          cfg_index <= REG_NONE;
          cfg_data  <= 8'($urandom_range(255));
        end
      endcase
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    amb_red   = r;
    amb_green = g;
    amb_blue  = b;
    settings++;
  endtask

  task automatic check_beat();
    lit_px_t want;
    lit_px_t got;
    got.red    = out_red;
    got.green  = out_green;
    got.blue   = out_blue;
    got.passed = out_passed_through;
    beats_out++;
    if (combined_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("tb: cycle %0d unexpected beat rgb %h %h %h pass %b",
                 cycles, got.red, got.green, got.blue, got.passed);
      return;
    end
    want = combined_q.pop_front();
    if (want.passed) passes_seen++;
    if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
        got.passed !== want.passed) begin
      mismatches++;
      if (mismatches <= 10)
        $display("tb: cycle %0d beat %0d want rgb %h %h %h pass %b, got rgb %h %h %h pass %b",
                 cycles, beats_out, want.red, want.green, want.blue, want.passed,
                 got.red, got.green, got.blue, got.passed);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) check_beat();
      if (hold_seen != hold_asks) begin
        hold_seen <= hold_asks;
        hold_left <= LONG_HOLD;
        out_stall <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !steady && ($urandom_range(99) < 21);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: timeout after %0d cycles, %0d beats outstanding", cycles, combined_q.size());
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    pix_in_t px;
    lit_px_t want;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < $size(PROBES); i++) begin
      px = '{PROBES[i].red, PROBES[i].green, PROBES[i].blue, PROBES[i].level,
             PROBES[i].bright};
      if (PROBES[i].known)
        want = '{PROBES[i].w_red, PROBES[i].w_green, PROBES[i].w_blue, PROBES[i].w_passed};
      else
        want = combine_pixel(px);
      send_pixel(px, want, 1'b0);
    end
    in_valid <= 1'b0;

    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_drained();
      case (ph)
        0: set_ambient(8'hff, 8'hff, 8'hff);
        1: set_ambient(8'h00, 8'h00, 8'h00);
        2: set_ambient(8'hff, 8'h00, 8'h80);
        default: set_ambient(pick_byte(), pick_byte(), pick_byte());
      endcase
      // phase 1 runs with no idling on either side
      steady <= (ph == 1);
      for (int n = 0; n < PHASE_PIX; n++) begin
        // hold the output off while pixels keep coming, to back up the pipeline
        if (ph == 2 && n == 10) hold_asks <= hold_asks + 1;
        px = random_pixel();
        send_pixel(px, combine_pixel(px), ph == 1);
      end
      in_valid <= 1'b0;
    end

    wait_drained();
    $display("tb: %0d pixels in, %0d beats out, %0d pass-through, %0d ambient settings",
             pixels_in, beats_out, passes_seen, settings);
    if (mismatches == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: %0d mismatching beats", mismatches);
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
